/* src/tfa_pkg.sv */
// Shared widths, constants and the arctangent table for the trilateration block.
package tfa_pkg;

  localparam int CFG_W  = 15;   // anchor coordinate
  localparam int RNG_W  = 17;   // measured range
  localparam int POS_W  = 21;   // solved coordinate
  localparam int HDG_W  = 16;   // heading in centidegrees
  localparam int ACT_W  = 3;
  localparam int ACC_W  = 60;   // product accumulator
  localparam int MUL_AW = 38;   // multiplicand
  localparam int MUL_BW = 22;   // multiplier, one bit per cycle
  localparam int SQ_W   = 44;   // x*x + y*y
  localparam int ANG_W  = 26;   // angle, 1/256 centidegree
  localparam int STEP_W = 5;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_TAB_LEN   = 24;

  localparam int POS_LIMIT = 1000000;
  localparam int ANG_HALF  = 4608000;
  localparam int ANG_FULL  = 9216000;
  localparam int HDG_FULL  = 36000;

  localparam int FWD_MAX_CD    = 1500;
  localparam int FWD_MIN_CD    = 34500;
  localparam int RIGHT_MIN_CD  = 3000;
  localparam int TURN_SPLIT_CD = 18000;
  localparam int LEFT_MAX_CD   = 33000;
  localparam longint DIST_ENTER_SQ = 2700 * 2700;
  localparam longint DIST_EXIT_SQ  = 2300 * 2300;
  localparam longint BACK_ENTER_SQ = 1000 * 1000;
  localparam longint BACK_EXIT_SQ  = 1300 * 1300;

  localparam logic [ACT_W-1:0] ACT_HOLD  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FWD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BACK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LEFT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RIGHT = 3'd4;

  localparam logic [2:0] CFG_AX = 3'd0;
  localparam logic [2:0] CFG_AY = 3'd1;
  localparam logic [2:0] CFG_BX = 3'd2;
  localparam logic [2:0] CFG_BY = 3'd3;
  localparam logic [2:0] CFG_CX = 3'd4;
  localparam logic [2:0] CFG_CY = 3'd5;

  function automatic logic [20:0] atan_lut(input logic [4:0] i);
    logic [20:0] r;
    unique case (i)
      5'd0:  r = 21'd1152000;
      5'd1:  r = 21'd680065;
      5'd2:  r = 21'd359328;
      5'd3:  r = 21'd182400;
      5'd4:  r = 21'd91554;
      5'd5:  r = 21'd45822;
      5'd6:  r = 21'd22916;
      5'd7:  r = 21'd11459;
      5'd8:  r = 21'd5730;
      5'd9:  r = 21'd2865;
      5'd10: r = 21'd1432;
      5'd11: r = 21'd716;
      5'd12: r = 21'd358;
      5'd13: r = 21'd179;
      5'd14: r = 21'd90;
      5'd15: r = 21'd45;
      5'd16: r = 21'd22;
      5'd17: r = 21'd11;
      5'd18: r = 21'd6;
      5'd19: r = 21'd3;
      5'd20: r = 21'd1;
      5'd21: r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/trilateration_follow_action.sv */
// Top level: three-anchor trilateration with heading, range and follow action.
//
// Usage:
//   s_* stream carries one request: three anchor ranges in millimetres.
//   m_* stream returns one result per request: action, position, heading,
//   range, and the singular flag on m_tuser.
//   cfg_we/cfg_addr/cfg_data write the six anchor coordinates (indexes 0..5,
//   a_x a_y b_x b_y c_x c_y); other indexes are ignored. Write only while idle.
// Schedule:
//   One request at a time. The serial multiplier runs 20 products, the
//   divider two quotients (skipped when the determinant is zero), then
//   CORDIC and square root run side by side. The one-bit-per-cycle
//   multiplier and divider set the time per request.
// Reset:
//   Anchors return to their defaults, hysteresis flags clear, output empty.
// Stall:
//   The result sits in the output register until m_tready; s_tready rises
//   again as soon as the result is loaded, so a new request can be worked on
//   while the previous result waits. A finished request waits for the slot.
module trilateration_follow_action #(
  parameter int CORDIC_STEPS = tfa_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // range_a_mm, range_b_mm, range_c_mm, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // action, pos_x_mm, pos_y_mm, heading_cdeg, range_mm, pad
  output logic [0:0]  m_tuser,   // singular
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [tfa_pkg::CFG_W-1:0] cfg_data
);
  import tfa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIVX = 3'd2;
  localparam logic [2:0] S_DIVY = 3'd3;
  localparam logic [2:0] S_CORD = 3'd4;
  localparam logic [2:0] S_ACT  = 3'd5;

  // product program: c = 0..5, f = 6..11, det = 12..13, num_x = 14..15,
  // num_y = 16..17, x*x + y*y = 18..19
  localparam logic [STEP_W-1:0] ST_C_END  = 5'd5;
  localparam logic [STEP_W-1:0] ST_F_END  = 5'd11;
  localparam logic [STEP_W-1:0] ST_D_END  = 5'd13;
  localparam logic [STEP_W-1:0] ST_NX_END = 5'd15;
  localparam logic [STEP_W-1:0] ST_NY_END = 5'd17;
  localparam logic [STEP_W-1:0] ST_SQ     = 5'd18;
  localparam logic [STEP_W-1:0] ST_LAST   = 5'd19;

  logic [2:0] state;
  logic [STEP_W-1:0] step;
  logic kick, dkick, ckick;

  logic signed [CFG_W-1:0] ax, ay, bx, by, cx, cy;
  logic [RNG_W-1:0] ra, rb, rc;

  // linearized system coefficients
  logic signed [CFG_W:0] dba_x, dba_y, dcb_x, dcb_y;
  logic signed [CFG_W+1:0] co_a, co_b, co_d, co_e;
  assign dba_x = {bx[CFG_W-1], bx} - {ax[CFG_W-1], ax};
  assign dba_y = {by[CFG_W-1], by} - {ay[CFG_W-1], ay};
  assign dcb_x = {cx[CFG_W-1], cx} - {bx[CFG_W-1], bx};
  assign dcb_y = {cy[CFG_W-1], cy} - {by[CFG_W-1], by};
  assign co_a = {dba_x, 1'b0};
  assign co_b = {dba_y, 1'b0};
  assign co_d = {dcb_x, 1'b0};
  assign co_e = {dcb_y, 1'b0};

  logic signed [MUL_AW-1:0] c_r, f_r;
  logic signed [ACC_W-1:0] det_r, numx_r, numy_r;
  logic [SQ_W-1:0] s_r;
  logic signed [POS_W-1:0] x_r, y_r;
  logic sing_r;
  logic [HDG_W-1:0] h_r;
  logic [POS_W-1:0] rng_r;
  logic cg, sg;
  logic turning, forward, backward;

  // operand select
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic mul_sub, mul_clr;

  function automatic logic signed [MUL_AW-1:0] sa15(input logic signed [CFG_W-1:0] v);
    return MUL_AW'(v);
  endfunction
  function automatic logic signed [MUL_BW-1:0] sb15(input logic signed [CFG_W-1:0] v);
    return MUL_BW'(v);
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      5'd0, 5'd6:  begin mul_a = MUL_AW'(ra); mul_b = MUL_BW'(ra); end
      5'd1, 5'd7:  begin
        mul_a = (step == 5'd1) ? MUL_AW'(rb) : MUL_AW'(rc);
        mul_b = (step == 5'd1) ? MUL_BW'(rb) : MUL_BW'(rc);
      end
      5'd2:  begin mul_a = sa15(ax); mul_b = sb15(ax); end
      5'd3:  begin mul_a = sa15(ay); mul_b = sb15(ay); end
      5'd4, 5'd8:  begin mul_a = sa15(bx); mul_b = sb15(bx); end
      5'd5, 5'd9:  begin mul_a = sa15(by); mul_b = sb15(by); end
      5'd10: begin mul_a = sa15(cx); mul_b = sb15(cx); end
      5'd11: begin mul_a = sa15(cy); mul_b = sb15(cy); end
      5'd12: begin mul_a = MUL_AW'(co_a); mul_b = MUL_BW'(co_e); end
      5'd13: begin mul_a = MUL_AW'(co_b); mul_b = MUL_BW'(co_d); end
      5'd14: begin mul_a = c_r; mul_b = MUL_BW'(co_e); end
      5'd15: begin mul_a = f_r; mul_b = MUL_BW'(co_b); end
      5'd16: begin mul_a = f_r; mul_b = MUL_BW'(co_a); end
      5'd17: begin mul_a = c_r; mul_b = MUL_BW'(co_d); end
      5'd18: begin mul_a = MUL_AW'(x_r); mul_b = MUL_BW'(x_r); end
      5'd19: begin mul_a = MUL_AW'(y_r); mul_b = MUL_BW'(y_r); end
      default: ;
    endcase
    // step 6 takes rb, not ra
    if (step == 5'd6) begin
      mul_a = MUL_AW'(rb);
      mul_b = MUL_BW'(rb);
    end
    mul_sub = (step == 5'd1) || (step == 5'd2) || (step == 5'd3) || (step == 5'd7) ||
              (step == 5'd8) || (step == 5'd9) || (step == 5'd13) || (step == 5'd15) ||
              (step == 5'd17);
    mul_clr = (step == 5'd0) || (step == 5'd6) || (step == 5'd12) || (step == 5'd14) ||
              (step == 5'd16) || (step == ST_SQ);
  end

  logic signed [ACC_W-1:0] acc;
  logic mul_done;
  tfa_mul u_mul (
    .clk(clk), .rst(rst), .start(kick), .clr(mul_clr), .sub(mul_sub),
    .a(mul_a), .b(mul_b), .acc(acc), .done(mul_done)
  );

  logic signed [POS_W-1:0] div_q;
  logic div_done;
  tfa_div u_div (
    .clk(clk), .rst(rst), .start(dkick),
    .num((state == S_DIVX) ? numx_r : numy_r), .den(det_r),
    .q(div_q), .done(div_done)
  );

  logic [HDG_W-1:0] cord_h;
  logic cord_done;
  tfa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(ckick), .x(x_r), .y(y_r),
    .h(cord_h), .done(cord_done)
  );

  logic [POS_W-1:0] sq_r;
  logic sq_done;
  tfa_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(ckick), .s(s_r), .r(sq_r), .done(sq_done)
  );

  // follow action with hysteresis
  logic ahead, right, left, go;
  logic turning_next, forward_next, backward_next;
  logic [ACT_W-1:0] act;
  always_comb begin
    ahead = (h_r <= HDG_W'(FWD_MAX_CD)) || (h_r >= HDG_W'(FWD_MIN_CD));
    right = (h_r > HDG_W'(RIGHT_MIN_CD)) && (h_r <= HDG_W'(TURN_SPLIT_CD));
    left  = (h_r >= HDG_W'(TURN_SPLIT_CD)) && (h_r < HDG_W'(LEFT_MAX_CD));
    turning_next  = turning;
    forward_next  = forward;
    backward_next = backward;
    act = ACT_HOLD;
    go  = 1'b0;
    if (turning && !ahead) begin
      // dead band between the turn sectors holds
      act = right ? ACT_RIGHT : (left ? ACT_LEFT : ACT_HOLD);
    end else begin
      if (turning) turning_next = 1'b0;
      if (right) begin
        turning_next = 1'b1;
        act = ACT_RIGHT;
      end else if (left) begin
        turning_next = 1'b1;
        act = ACT_LEFT;
      end else if (backward) begin
        if (s_r > SQ_W'(BACK_EXIT_SQ)) begin
          backward_next = 1'b0;
          go = 1'b1;
        end else begin
          act = ACT_BACK;
        end
      end else if (s_r < SQ_W'(BACK_ENTER_SQ)) begin
        backward_next = 1'b1;
        act = ACT_BACK;
      end else begin
        go = 1'b1;
      end
      if (go) begin
        if (forward) begin
          if (s_r < SQ_W'(DIST_EXIT_SQ)) begin
            forward_next = 1'b0;
            act = ACT_HOLD;
          end else begin
            act = ACT_FWD;
          end
        end else if (s_r > SQ_W'(DIST_ENTER_SQ)) begin
          forward_next = 1'b1;
          act = ACT_FWD;
        end
      end
    end
  end

  // result register takes a new result when empty or being drained
  logic load;
  assign load = (state == S_ACT) && (!m_tvalid || m_tready);

  assign s_tready = (state == S_IDLE);

  // anchor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= -15'sd250;
      ay <= '0;
      bx <= 15'sd250;
      by <= '0;
      cx <= '0;
      cy <= -15'sd550;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_AX: ax <= cfg_data;
        CFG_AY: ay <= cfg_data;
        CFG_BX: bx <= cfg_data;
        CFG_BY: by <= cfg_data;
        CFG_CX: cx <= cfg_data;
        CFG_CY: cy <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      kick     <= 1'b0;
      dkick    <= 1'b0;
      ckick    <= 1'b0;
      cg       <= 1'b0;
      sg       <= 1'b0;
      m_tvalid <= 1'b0;
      turning  <= 1'b0;
      forward  <= 1'b0;
      backward <= 1'b0;
    end else begin
      kick  <= 1'b0;
      dkick <= 1'b0;
      ckick <= 1'b0;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ra    <= s_tdata[16:0];
            rb    <= s_tdata[33:17];
            rc    <= s_tdata[50:34];
            step  <= '0;
            kick  <= 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            unique case (step)
              ST_C_END:  c_r    <= acc[MUL_AW-1:0];
              ST_F_END:  f_r    <= acc[MUL_AW-1:0];
              ST_D_END:  det_r  <= acc;
              ST_NX_END: numx_r <= acc;
              ST_NY_END: numy_r <= acc;
              ST_LAST:   s_r    <= acc[SQ_W-1:0];
              default: ;
            endcase
            if (step == ST_NY_END) begin
              if (det_r == '0) begin
                x_r    <= '0;
                y_r    <= '0;
                sing_r <= 1'b1;
                step   <= ST_SQ;
                kick   <= 1'b1;
              end else begin
                sing_r <= 1'b0;
                dkick  <= 1'b1;
                state  <= S_DIVX;
              end
            end else if (step == ST_LAST) begin
              ckick <= 1'b1;
              cg    <= 1'b0;
              sg    <= 1'b0;
              state <= S_CORD;
            end else begin
              step <= step + 1'b1;
              kick <= 1'b1;
            end
          end
        end
        S_DIVX: begin
          if (div_done) begin
            x_r   <= div_q;
            dkick <= 1'b1;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            y_r   <= div_q;
            step  <= ST_SQ;
            kick  <= 1'b1;
            state <= S_MUL;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            h_r <= cord_h;
            cg  <= 1'b1;
          end
          if (sq_done) begin
            rng_r <= sq_r;
            sg    <= 1'b1;
          end
          if (cg && sg) state <= S_ACT;
        end
        S_ACT: begin
          if (load) begin
            m_tdata  <= {6'b0, rng_r, h_r, y_r, x_r, act};
            m_tuser  <= sing_r;
            turning  <= turning_next;
            forward  <= forward_next;
            backward <= backward_next;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a singular result always reports the origin
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[44:3] == '0))
    else $error("singular result with nonzero position");

  // heading stays below a full turn
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[60:45] < 16'd36000))
    else $error("heading out of range");

  // product program never runs past its last step
  assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> step <= ST_LAST)
    else $error("product step overrun");

  // divider is only started with a nonzero determinant
  assert property (@(posedge clk) disable iff (rst)
    dkick |-> det_r != '0)
    else $error("division by zero determinant");
endmodule

/* src/tfa_mul.sv */
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
module tfa_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic clr,
  input  logic sub,
  input  logic signed [tfa_pkg::MUL_AW-1:0] a,
  input  logic signed [tfa_pkg::MUL_BW-1:0] b,
  output logic signed [tfa_pkg::ACC_W-1:0]  acc,
  output logic done
);
  import tfa_pkg::*;
  localparam int CW = $clog2(MUL_BW);

  logic signed [ACC_W-1:0] ar, term;
  logic [MUL_BW-1:0] br;
  logic [CW-1:0] cnt;
  logic busy, neg, last;

  assign term = br[0] ? ar : '0;
  assign last = (cnt == CW'(MUL_BW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar   <= ACC_W'(a);
        br   <= b;
        cnt  <= '0;
        neg  <= sub;
        busy <= 1'b1;
        if (clr) acc <= '0;
      end else if (busy) begin
        // top bit of a two's complement multiplier weighs negative
        acc <= (last ^ neg) ? acc - term : acc + term;
        ar  <= ar <<< 1;
        br  <= br >> 1;
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/tfa_div.sv */
// Restoring divider: rounded, saturated quotient, one bit per cycle.
module tfa_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [tfa_pkg::ACC_W-1:0] num,
  input  logic signed [tfa_pkg::ACC_W-1:0] den,
  output logic signed [tfa_pkg::POS_W-1:0] q,
  output logic done
);
  import tfa_pkg::*;
  localparam int NW = ACC_W + 1;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] nreg, dreg;
  logic [NW:0]   rem, rem_sh;
  logic [ACC_W-1:0] na, da;
  logic [CW-1:0] cnt;
  logic [POS_W-1:0] mag;
  logic busy, neg, fits;

  assign na = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign da = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
  assign rem_sh = {rem[NW-1:0], nreg[NW-1]};
  assign fits = rem_sh >= {1'b0, dreg};
  assign mag = (nreg > NW'(POS_LIMIT)) ? POS_W'(POS_LIMIT) : nreg[POS_W-1:0];
  assign q = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // (2n + d) / (2d) rounds half away from zero
        nreg <= {na, 1'b0} + NW'(da);
        dreg <= {da, 1'b0};
        rem  <= '0;
        cnt  <= '0;
        neg  <= num[ACC_W-1] ^ den[ACC_W-1];
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? rem_sh - {1'b0, dreg} : rem_sh;
        nreg <= {nreg[NW-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/tfa_cordic.sv */
// Vectoring CORDIC for atan2(x, y), one rotation per cycle.
module tfa_cordic #(
  parameter int STEPS = tfa_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [tfa_pkg::POS_W-1:0] x,
  input  logic signed [tfa_pkg::POS_W-1:0] y,
  output logic [tfa_pkg::HDG_W-1:0] h,
  output logic done
);
  import tfa_pkg::*;
  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int VW = POS_W + 19;

  logic signed [VW-1:0] u, v, u0, v0;
  logic signed [ANG_W-1:0] z, zw;
  logic [ANG_W-1:0] zp;
  logic [ANG_W-9:0] hh;
  logic [IW-1:0] i;
  logic busy, fin, zero;

  assign u0 = {{3{y[POS_W-1]}}, y, 16'b0};
  assign v0 = {{3{x[POS_W-1]}}, x, 16'b0};

  always_comb begin
    if (z < 0) zw = z + ANG_W'(ANG_FULL);
    else if (z >= ANG_W'(ANG_FULL)) zw = z - ANG_W'(ANG_FULL);
    else zw = z;
    zp = zw + ANG_W'(128);
    hh = zp[ANG_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        zero <= (x == '0) && (y == '0);
        if (y[POS_W-1]) begin
          u <= -u0;
          v <= -v0;
          z <= ANG_W'(ANG_HALF);
        end else begin
          u <= u0;
          v <= v0;
          z <= '0;
        end
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (v > 0) begin
          u <= u + (v >>> i);
          v <= v - (u >>> i);
          z <= z + ANG_W'(atan_lut(5'(i)));
        end else begin
          u <= u - (v >>> i);
          v <= v + (u >>> i);
          z <= z - ANG_W'(atan_lut(5'(i)));
        end
        i <= i + 1'b1;
        if (i == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (zero) h <= '0;
        else if (hh >= (ANG_W-8)'(HDG_FULL)) h <= HDG_W'(hh - (ANG_W-8)'(HDG_FULL));
        else h <= HDG_W'(hh);
      end
    end
  end
endmodule

/* src/tfa_sqrt.sv */
// Rounded integer square root, one result bit per cycle.
module tfa_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [tfa_pkg::SQ_W-1:0]  s,
  output logic [tfa_pkg::POS_W-1:0] r,
  output logic done
);
  import tfa_pkg::*;
  localparam int IT = SQ_W / 2;
  localparam int CW = $clog2(IT);

  logic [SQ_W-1:0] sr, rr, bitr, trial;
  logic [CW-1:0] cnt;
  logic busy, fin;

  assign trial = rr + bitr;
  assign r = rr[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sr   <= s;
        rr   <= '0;
        bitr <= SQ_W'(1) << (SQ_W - 2);
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (sr >= trial) begin
          sr <= sr - trial;
          rr <= (rr >> 1) + bitr;
        end else begin
          rr <= rr >> 1;
        end
        bitr <= bitr >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(IT - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (sr > rr) rr <= rr + 1'b1;
      end
    end
  end
endmodule
